// ----- rtl/tkpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tkpc_pkg
// Shared types, codes and the per-key tick function of the two-key press
// classifier.
// ----------------------------------------------------------------------------
package tkpc_pkg;

    // Configuration register indexes.
    localparam int CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] CFG_DEBOUNCE_TICKS   = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CFG_LONG_PRESS_TICKS = 1'b1;
    localparam int CfgDataWidth = 16;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DEBOUNCE_TICKS_RESET   = 8'd5;
    localparam logic [15:0] LONG_PRESS_TICKS_RESET = 16'd1500;

    // Event codes reported on the result and latched into the slots.
    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_SHORT_START = 3'd1,
        EV_LONG_START  = 3'd2,
        EV_SHORT_KEEP  = 3'd3,
        EV_LONG_KEEP   = 3'd4
    } t_event;

    // Outcome of one key for one tick.
    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } t_press;

    // Next state of one key and what it reports.
    typedef struct packed {
        logic [7:0]  deb;
        logic [15:0] hold;
        t_press      press;
    } t_key_step;

    // Runs one key for one tick: debounce, then hold counting once qualified.
    function automatic t_key_step key_tick(
        input logic        pressed,
        input logic [7:0]  deb,
        input logic [15:0] hold,
        input logic [7:0]  deb_ticks,
        input logic [15:0] long_ticks
    );
        t_key_step   s;
        logic [16:0] h;
        logic [16:0] thr;
        s.deb   = deb;
        s.hold  = '0;
        s.press = PRESS_NONE;
        h       = {1'b0, hold} + 17'd1;
        thr     = {1'b0, long_ticks};
        if (deb > deb_ticks) begin
            // Qualified press: count hold ticks, stop at the threshold.
            if (pressed) begin
                if (h == thr) begin
                    s.press = PRESS_LONG;
                end else if (h > thr) begin
                    h = thr;
                end
            end else begin
                if (h < thr) begin
                    s.press = PRESS_SHORT;
                end
                s.deb = '0;
            end
            s.hold = h[16] ? 16'hFFFF : h[15:0];
        end else begin
            // Still debouncing: saturating run counter.
            if (pressed) begin
                if (deb != 8'hFF) begin
                    s.deb = deb + 8'd1;
                end
            end else begin
                s.deb = '0;
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/tkpc_in_if.sv -----
// ----------------------------------------------------------------------------
// tkpc_in_if
// Input channel: one beat per 1 ms tick with key levels and slot acks.
// ----------------------------------------------------------------------------
interface tkpc_in_if;
    logic valid;
    logic ready;
    logic start_key_level;
    logic keep_key_level;
    logic ack_timer_slot;
    logic ack_kettle_slot;
    logic ack_unit_slot;

    modport source (
        output valid, start_key_level, keep_key_level,
               ack_timer_slot, ack_kettle_slot, ack_unit_slot,
        input  ready
    );
    modport sink (
        input  valid, start_key_level, keep_key_level,
               ack_timer_slot, ack_kettle_slot, ack_unit_slot,
        output ready
    );
endinterface

// ----- rtl/tkpc_out_if.sv -----
// ----------------------------------------------------------------------------
// tkpc_out_if
// Result channel: one beat per tick with the event, the slots and the totals.
// ----------------------------------------------------------------------------
interface tkpc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic [2:0]  timer_slot;
    logic [2:0]  kettle_slot;
    logic [2:0]  unit_slot;
    logic [31:0] start_press_total;
    logic [31:0] keep_press_total;

    modport source (
        output valid, event_code, timer_slot, kettle_slot, unit_slot,
               start_press_total, keep_press_total,
        input  ready
    );
    modport sink (
        input  valid, event_code, timer_slot, kettle_slot, unit_slot,
               start_press_total, keep_press_total,
        output ready
    );
endinterface

// ----- rtl/two_key_press_classifier_core.sv -----
// ----------------------------------------------------------------------------
// two_key_press_classifier_core
// Debounces a start key and a keep key, classifies short and long presses,
// latches events into three read-and-clear slots and keeps press totals.
// ----------------------------------------------------------------------------
// Each input beat is one 1 ms tick. The block takes one beat per clock cycle;
// its result appears in the result register in the cycle after acceptance, and
// the next beat is accepted in the same cycle as long as that register is
// empty or being taken. The key counters, slots and totals are updated by
// one pass of logic between the accepted beat and the result register, so
// the throughput is set by that single register stage. Configuration writes
// (debounce threshold, long-press threshold) belong in idle periods.
module two_key_press_classifier_core
    import tkpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_wdata,
    tkpc_in_if.sink                  i_item,
    tkpc_out_if.source               o_result
);

    // Configuration registers.
    logic [7:0]  r_debounce_ticks;
    logic [15:0] r_long_press_ticks;

    // Key state, slots and totals.
    logic [7:0]  r_start_deb;
    logic [15:0] r_start_hold;
    logic [7:0]  r_keep_deb;
    logic [15:0] r_keep_hold;
    t_event      r_slot_timer;
    t_event      r_slot_kettle;
    t_event      r_slot_unit;
    logic [31:0] r_start_total;
    logic [31:0] r_keep_total;

    // Result register.
    logic        r_out_valid;
    t_event      r_event;

    // Next values.
    t_key_step   n_start;
    t_key_step   n_keep;
    t_event      n_event;
    t_event      n_slot_timer;
    t_event      n_slot_kettle;
    t_event      n_slot_unit;
    logic [31:0] n_start_total;
    logic [31:0] n_keep_total;

    logic        w_accept;

    // The result register frees up when its beat is taken.
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    // One tick: acks first, start key, then keep key.
    always_comb begin
        n_slot_timer  = i_item.ack_timer_slot  ? EV_NONE : r_slot_timer;
        n_slot_kettle = i_item.ack_kettle_slot ? EV_NONE : r_slot_kettle;
        n_slot_unit   = i_item.ack_unit_slot   ? EV_NONE : r_slot_unit;
        n_event       = EV_NONE;
        n_start_total = r_start_total;
        n_keep_total  = r_keep_total;

        n_start = key_tick(!i_item.start_key_level, r_start_deb, r_start_hold,
                           r_debounce_ticks, r_long_press_ticks);
        n_keep  = key_tick(!i_item.keep_key_level, r_keep_deb, r_keep_hold,
                           r_debounce_ticks, r_long_press_ticks);

        // A start event while the keep key is debouncing or held is only a combo.
        if (n_start.press != PRESS_NONE) begin
            n_start_total = r_start_total + 32'd1;
            if (r_keep_deb == '0) begin
                n_event = (n_start.press == PRESS_SHORT) ? EV_SHORT_START
                                                         : EV_LONG_START;
            end
        end

        // The keep key sees the start key's counter after this tick.
        if (n_keep.press != PRESS_NONE) begin
            n_keep_total = r_keep_total + 32'd1;
            if (n_start.deb == '0) begin
                n_event = (n_keep.press == PRESS_SHORT) ? EV_SHORT_KEEP
                                                        : EV_LONG_KEEP;
            end
        end

        if (n_event != EV_NONE) begin
            n_slot_timer  = n_event;
            n_slot_kettle = n_event;
            n_slot_unit   = n_event;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= DEBOUNCE_TICKS_RESET;
            r_long_press_ticks <= LONG_PRESS_TICKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TICKS: begin
                    r_debounce_ticks <= i_cfg_wdata[7:0];
                end
                CFG_LONG_PRESS_TICKS: begin
                    r_long_press_ticks <= i_cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Key state, slots and totals advance on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_deb   <= '0;
            r_start_hold  <= '0;
            r_keep_deb    <= '0;
            r_keep_hold   <= '0;
            r_slot_timer  <= EV_NONE;
            r_slot_kettle <= EV_NONE;
            r_slot_unit   <= EV_NONE;
            r_start_total <= '0;
            r_keep_total  <= '0;
        end else if (w_accept) begin
            r_start_deb   <= n_start.deb;
            r_start_hold  <= n_start.hold;
            r_keep_deb    <= n_keep.deb;
            r_keep_hold   <= n_keep.hold;
            r_slot_timer  <= n_slot_timer;
            r_slot_kettle <= n_slot_kettle;
            r_slot_unit   <= n_slot_unit;
            r_start_total <= n_start_total;
            r_keep_total  <= n_keep_total;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_out_valid <= i_item.valid;
        end
    end

    // Event code of the result beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_event <= n_event;
        end
    end

    // The slots and totals registers hold exactly the values of the last beat.
    assign o_result.valid             = r_out_valid;
    assign o_result.event_code        = r_event;
    assign o_result.timer_slot        = r_slot_timer;
    assign o_result.kettle_slot       = r_slot_kettle;
    assign o_result.unit_slot         = r_slot_unit;
    assign o_result.start_press_total = r_start_total;
    assign o_result.keep_press_total  = r_keep_total;

endmodule
